[rtl/alux_pkg.sv]
// ----------------------------------------------------------------------------
// alux_pkg
// Types and constants shared by the ambient light lux calculator.
// ----------------------------------------------------------------------------
package alux_pkg;

  // integration_select codes
  localparam logic [1:0] INTEG_13MS   = 2'd0;
  localparam logic [1:0] INTEG_101MS  = 2'd1;
  localparam logic [1:0] INTEG_402MS  = 2'd2;
  localparam logic [1:0] INTEG_MANUAL = 2'd3;

  // register index (paddr[2])
  localparam logic REG_INTEG = 1'b0;
  localparam logic REG_GAIN  = 1'b1;

  localparam logic [1:0] INTEG_RESET = INTEG_402MS;
  localparam logic       GAIN_RESET  = 1'b0;

  // segment coefficients
  localparam logic [27:0] K_SEGA_C0 = 28'd2240;
  localparam logic [27:0] K_SEGA_C1 = 28'd3100;
  localparam logic [27:0] K_SEGB_C0 = 28'd1280;
  localparam logic [27:0] K_SEGB_C1 = 28'd1530;
  localparam logic [27:0] K_SEGC_C0 = 28'd146;
  localparam logic [27:0] K_SEGC_C1 = 28'd112;

  // first segment: c0 * (3040 * 2^16 - 6200 * p)
  localparam logic [27:0] K_POW_BASE  = 28'd199229440;
  localparam logic [12:0] K_POW_SLOPE = 13'd6200;

  // final divisors 54400 = 2^7*425, 403200 = 2^8*1575, 1600000 = 2^9*3125
  // rounding offset is half the divisor
  localparam logic [19:0] HALF_13MS  = 20'd27200;
  localparam logic [19:0] HALF_101MS = 20'd201600;
  localparam logic [19:0] HALF_402MS = 20'd800000;

  // ceil(2^54 / odd part), exact for a pre-shifted value below 2^42
  localparam logic [45:0] RCP_13MS  = 46'd42386820022311;
  localparam logic [45:0] RCP_101MS = 46'd11437713339354;
  localparam logic [45:0] RCP_402MS = 46'd5764607523035;

  typedef enum logic [2:0] {
    SEG_POW,
    SEG_A,
    SEG_B,
    SEG_C,
    SEG_NONE
  } seg_t;

  typedef struct packed {
    logic [15:0] c0;
    logic [1:0]  sel;
    logic        gain;
    seg_t        seg;
    logic [27:0] mlin;
  } item_t;

  typedef struct packed {
    logic status;
    logic zero;
  } tail_t;

endpackage

[rtl/alux_div_pipe.sv]
// ----------------------------------------------------------------------------
// alux_div_pipe
// Pipelined restoring divider, one quotient bit per stage, with side payload.
// ----------------------------------------------------------------------------
module alux_div_pipe #(
  parameter int NW = 40,
  parameter int DW = 16,
  parameter int QW = 23,
  parameter int PW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [PW-1:0] pay_in,
  output logic          out_valid,
  output logic [QW-1:0] quo,
  output logic [PW-1:0] pay_out
);

  localparam int CW = ((NW > DW + QW) ? NW : DW + QW) + 1;

  logic [NW-1:0] rem_r [QW];
  logic [DW-1:0] den_r [QW];
  logic [QW-1:0] quo_r [QW];
  logic [PW-1:0] pay_r [QW];
  logic [QW-1:0] vld_r;

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [NW-1:0] rem_in;
    logic [DW-1:0] den_in;
    logic [QW-1:0] quo_in;
    logic [PW-1:0] pay_in_k;
    logic          vld_in;
    logic [CW-1:0] shifted;
    logic          ge;
    logic [NW-1:0] rem_next;
    logic [QW-1:0] quo_next;

    if (k == 0) begin : g_first
      assign rem_in   = num;
      assign den_in   = den;
      assign quo_in   = '0;
      assign pay_in_k = pay_in;
      assign vld_in   = in_valid;
    end else begin : g_rest
      assign rem_in   = rem_r[k-1];
      assign den_in   = den_r[k-1];
      assign quo_in   = quo_r[k-1];
      assign pay_in_k = pay_r[k-1];
      assign vld_in   = vld_r[k-1];
    end

    always_comb begin
      shifted  = CW'(den_in) << (QW - 1 - k);
      ge       = CW'(rem_in) >= shifted;
      rem_next = ge ? NW'(CW'(rem_in) - shifted) : rem_in;
      quo_next = ge ? (quo_in | (QW'(1) << (QW - 1 - k))) : quo_in;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_in;
      end
      if (en) begin
        rem_r[k] <= rem_next;
        den_r[k] <= den_in;
        quo_r[k] <= quo_next;
        pay_r[k] <= pay_in_k;
      end
    end
  end

  assign out_valid = vld_r[QW-1];
  assign quo       = quo_r[QW-1];
  assign pay_out   = pay_r[QW-1];

endmodule

[rtl/ambient_light_lux_calc_unit.sv]
// ----------------------------------------------------------------------------
// ambient_light_lux_calc_unit
// Two-channel ambient light lux calculator, unsigned Q20.12 output.
// ----------------------------------------------------------------------------
// Fully pipelined: one count pair is accepted every cycle while the output
// side takes results. The pipeline is an input register, the ratio divider
// (one quotient bit per stage), four stages for table interpolation and the
// first-segment product, and four stages that round, pre-shift and divide
// by the integration constant through a reciprocal product, the last of
// which is the output register. A stall holds the whole pipeline.
module ambient_light_lux_calc_unit #(
  parameter int POW_TABLE_ENTRIES = 64
) (
  input  logic        clk,
  input  logic        rst,
  // tdata: broadband_count [15:0], infrared_count [31:16]
  input  logic [31:0] s_tdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  // tdata: lux_value [31:0]
  output logic [31:0] m_tdata,
  // tuser: status [0]
  output logic        m_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int N   = POW_TABLE_ENTRIES;
  localparam int QB  = $clog2(2 * N + 1);
  localparam int NW1 = QB + 32;
  localparam int QW1 = $clog2(N) + 17;
  localparam int IW  = $clog2(N + 1);
  localparam int PW1 = $bits(alux_pkg::item_t);

  // ---------------- table build ----------------
  function automatic logic [63:0] root_target(input logic [63:0] i, input logic [63:0] q);
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] quo;
    num = i * i;
    den = q * q;
    quo = '0;
    for (int k = 0; k < 65; k++) begin
      num = num << 1;
      quo = quo << 1;
      if (num >= den) begin
        num = num - den;
        quo = quo | 64'd1;
      end
    end
    return quo;
  endfunction

  function automatic logic [63:0] ldiv(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] r;
    logic [63:0] qo;
    r  = '0;
    qo = '0;
    for (int k = 63; k >= 0; k--) begin
      r = (r << 1) | ((a >> k) & 64'd1);
      qo = qo << 1;
      if (r >= b) begin
        r  = r - b;
        qo = qo | 64'd1;
      end
    end
    return qo;
  endfunction

  function automatic logic [15:0] pow_point(input int i, input int qi);
    logic [63:0] q;
    logic [63:0] t;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    q  = 64'(qi);
    t  = root_target(64'(i), q);
    lo = '0;
    hi = 64'd6400;
    for (int k = 0; k < 16; k++) begin
      if (lo < hi) begin
        mid = (lo + hi + 64'd1) >> 1;
        if (mid * mid * mid * mid * mid <= t) begin
          lo = mid;
        end else begin
          hi = mid - 64'd1;
        end
      end
    end
    return 16'(ldiv(64'd8 * 64'(i) * lo + (q >> 1), q));
  endfunction

  logic [15:0] pow_rom [0:N];
  for (genvar gi = 0; gi <= N; gi++) begin : g_rom
    localparam logic [15:0] PV = pow_point(gi, 2 * N);
    assign pow_rom[gi] = PV;
  end

  // ---------------- config ----------------
  logic [1:0] integ_sel;
  logic       gain_high;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      integ_sel <= alux_pkg::INTEG_RESET;
      gain_high <= alux_pkg::GAIN_RESET;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == alux_pkg::REG_INTEG) begin
        integ_sel <= pwdata[1:0];
      end else begin
        gain_high <= pwdata[0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == alux_pkg::REG_INTEG) begin
      prdata = {30'd0, integ_sel};
    end else begin
      prdata = {31'd0, gain_high};
    end
  end

  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en && !rst;

  // ---------------- stage A: input ----------------
  logic        a_valid;
  logic [15:0] a_c0;
  logic [15:0] a_c1;
  logic [1:0]  a_sel;
  logic        a_gain;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= s_tvalid;
    end
    if (en) begin
      a_c0   <= s_tdata[15:0];
      a_c1   <= s_tdata[31:16];
      a_sel  <= integ_sel;
      a_gain <= gain_high;
    end
  end

  alux_pkg::item_t a_item;
  logic [27:0]     ka;
  logic [27:0]     kb;
  logic [27:0]     pa;
  logic [27:0]     pb;
  logic [15:0]     c1m;
  logic [NW1-1:0]  num1;
  logic [15:0]     den1;

  always_comb begin
    a_item.c0   = a_c0;
    a_item.sel  = a_sel;
    a_item.gain = a_gain;
    if ({a_c1, 1'b0} <= {1'b0, a_c0}) begin
      a_item.seg = alux_pkg::SEG_POW;
    end else if (23'(a_c1) * 23'd100 <= 23'(a_c0) * 23'd61) begin
      a_item.seg = alux_pkg::SEG_A;
    end else if (19'(a_c1) * 19'd5 <= 19'(a_c0) * 19'd4) begin
      a_item.seg = alux_pkg::SEG_B;
    end else if (20'(a_c1) * 20'd10 <= 20'(a_c0) * 20'd13) begin
      a_item.seg = alux_pkg::SEG_C;
    end else begin
      a_item.seg = alux_pkg::SEG_NONE;
    end
    case (a_item.seg)
      alux_pkg::SEG_A: begin
        ka = alux_pkg::K_SEGA_C0;
        kb = alux_pkg::K_SEGA_C1;
      end
      alux_pkg::SEG_B: begin
        ka = alux_pkg::K_SEGB_C0;
        kb = alux_pkg::K_SEGB_C1;
      end
      alux_pkg::SEG_C: begin
        ka = alux_pkg::K_SEGC_C0;
        kb = alux_pkg::K_SEGC_C1;
      end
      default: begin
        ka = '0;
        kb = '0;
      end
    endcase
    pa          = 28'(a_c0) * ka;
    pb          = 28'(a_c1) * kb;
    a_item.mlin = (pa > pb) ? pa - pb : '0;
    c1m         = (a_item.seg == alux_pkg::SEG_POW) ? a_c1 : '0;
    num1        = (NW1'(c1m) * NW1'(2 * N)) << 16;
    den1        = (a_c0 == '0) ? 16'd1 : a_c0;
  end

  // ---------------- ratio divider ----------------
  logic           d1_valid;
  logic [QW1-1:0] d1_pos;
  logic [PW1-1:0] d1_pay;

  alux_div_pipe #(.NW(NW1), .DW(16), .QW(QW1), .PW(PW1)) u_div_ratio (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (a_valid),
    .num      (num1),
    .den      (den1),
    .pay_in   (a_item),
    .out_valid(d1_valid),
    .quo      (d1_pos),
    .pay_out  (d1_pay)
  );

  // ---------------- stage B: table read ----------------
  logic [IW-1:0]   idx;
  logic            isat;
  logic [IW-1:0]   idx1;

  assign idx  = d1_pos[16 +: IW];
  assign isat = idx >= IW'(N);
  assign idx1 = isat ? idx : idx + IW'(1);

  logic            b_valid;
  alux_pkg::item_t b_info;
  logic [15:0]     b_lo;
  logic [15:0]     b_diff;
  logic [15:0]     b_frac;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (en) begin
      b_valid <= d1_valid;
    end
    if (en) begin
      b_info <= alux_pkg::item_t'(d1_pay);
      b_lo   <= isat ? pow_rom[N] : pow_rom[idx];
      b_diff <= isat ? 16'd0 : pow_rom[idx1] - pow_rom[idx];
      b_frac <= d1_pos[15:0];
    end
  end

  // ---------------- stage C: interpolation product ----------------
  logic            c_valid;
  alux_pkg::item_t c_info;
  logic [15:0]     c_lo;
  logic [31:0]     c_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (en) begin
      c_valid <= b_valid;
    end
    if (en) begin
      c_info <= b_info;
      c_lo   <= b_lo;
      c_prod <= 32'(b_diff) * 32'(b_frac);
    end
  end

  // ---------------- stage D: slope term ----------------
  logic [16:0] p_val;
  assign p_val = 17'(c_lo) + 17'(c_prod[31:16]);

  logic            d_valid;
  alux_pkg::item_t d_info;
  logic [29:0]     d_pterm;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else if (en) begin
      d_valid <= c_valid;
    end
    if (en) begin
      d_info  <= c_info;
      d_pterm <= 30'(p_val) * 30'(alux_pkg::K_POW_SLOPE);
    end
  end

  // ---------------- stage E: first-segment product ----------------
  logic [27:0] coef;
  assign coef = (30'(alux_pkg::K_POW_BASE) > d_pterm) ?
                28'(30'(alux_pkg::K_POW_BASE) - d_pterm) : '0;

  logic            e_valid;
  alux_pkg::item_t e_info;
  logic [43:0]     e_m1;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else if (en) begin
      e_valid <= d_valid;
    end
    if (en) begin
      e_info <= d_info;
      e_m1   <= 44'(d_info.c0) * 44'(coef);
    end
  end

  // ---------------- stage F: round and pre-shift ----------------
  logic [43:0]     m_val;
  logic [47:0]     mg;
  logic [19:0]     half;
  logic [45:0]     rcp;
  logic [48:0]     rnd;
  logic [41:0]     xq;
  alux_pkg::tail_t e_tail;

  always_comb begin
    m_val = (e_info.seg == alux_pkg::SEG_POW) ? e_m1 : {e_info.mlin, 16'd0};
    mg    = e_info.gain ? 48'(m_val) : 48'(m_val) << 4;
    case (e_info.sel)
      alux_pkg::INTEG_13MS: begin
        half = alux_pkg::HALF_13MS;
        rcp  = alux_pkg::RCP_13MS;
      end
      alux_pkg::INTEG_101MS: begin
        half = alux_pkg::HALF_101MS;
        rcp  = alux_pkg::RCP_101MS;
      end
      default: begin
        half = alux_pkg::HALF_402MS;
        rcp  = alux_pkg::RCP_402MS;
      end
    endcase
    rnd = 49'(mg) + 49'(half);
    case (e_info.sel)
      alux_pkg::INTEG_13MS:  xq = rnd[48:7];
      alux_pkg::INTEG_101MS: xq = {1'b0, rnd[48:8]};
      default:               xq = {2'b0, rnd[48:9]};
    endcase
    e_tail.status = e_info.sel == alux_pkg::INTEG_MANUAL;
    e_tail.zero   = e_tail.status || (e_info.c0 == '0);
  end

  logic            f_valid;
  logic [41:0]     f_x;
  logic [45:0]     f_rcp;
  alux_pkg::tail_t f_tail;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (en) begin
      f_valid <= e_valid;
    end
    if (en) begin
      f_x    <= xq;
      f_rcp  <= rcp;
      f_tail <= e_tail;
    end
  end

  // ---------------- stage G: partial products ----------------
  logic            g_valid;
  logic [41:0]     g_hh;
  logic [41:0]     g_hl;
  logic [45:0]     g_lh;
  logic [45:0]     g_ll;
  alux_pkg::tail_t g_tail;

  always_ff @(posedge clk) begin
    if (rst) begin
      g_valid <= 1'b0;
    end else if (en) begin
      g_valid <= f_valid;
    end
    if (en) begin
      g_hh   <= 42'(f_x[41:23]) * 42'(f_rcp[45:23]);
      g_hl   <= 42'(f_x[41:23]) * 42'(f_rcp[22:0]);
      g_lh   <= 46'(f_x[22:0]) * 46'(f_rcp[45:23]);
      g_ll   <= 46'(f_x[22:0]) * 46'(f_rcp[22:0]);
      g_tail <= f_tail;
    end
  end

  // ---------------- stage H: middle sum ----------------
  logic            h_valid;
  logic [41:0]     h_hh;
  logic [47:0]     h_t;
  alux_pkg::tail_t h_tail;

  always_ff @(posedge clk) begin
    if (rst) begin
      h_valid <= 1'b0;
    end else if (en) begin
      h_valid <= g_valid;
    end
    if (en) begin
      h_hh   <= g_hh;
      h_t    <= 48'(g_hl) + 48'(g_lh) + 48'(g_ll[45:23]);
      h_tail <= g_tail;
    end
  end

  // ---------------- stage I: quotient, output register ----------------
  logic [64:0] i_sum;
  assign i_sum = {h_hh, 23'd0} + 65'(h_t);

  logic            i_valid;
  logic [33:0]     i_quo;
  alux_pkg::tail_t i_tail;

  always_ff @(posedge clk) begin
    if (rst) begin
      i_valid <= 1'b0;
    end else if (en) begin
      i_valid <= h_valid;
    end
    if (en) begin
      i_quo  <= i_sum[64:31];
      i_tail <= h_tail;
    end
  end

  assign m_tvalid = i_valid;
  assign m_tuser  = i_tail.status;
  assign m_tdata  = i_tail.zero ? 32'd0 :
                    (i_quo[33:32] != 2'b00) ? 32'hFFFF_FFFF : i_quo[31:0];

`ifndef SYNTHESIS
  a_manual_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == 32'd0)
    else $error("manual integration result not zero");

  a_ratio_unused: assert property (@(posedge clk) disable iff (rst)
    b_valid && b_info.seg != alux_pkg::SEG_POW |-> b_frac == 16'd0 && b_lo == pow_rom[0])
    else $error("ratio divider active outside power segment");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid && !e_valid)
    else $error("pipeline not empty after reset");
`endif

endmodule
